/* rtl/core/mpq_pkg.sv */
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int KEY_BITS    = 16;
    localparam int ID_BITS     = 8;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;
    localparam int DEPTH_DEF   = 16;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                req_type;
        logic [KEY_BITS-1:0] key;
        logic [ID_BITS-1:0]  job_id;
    } req_beat_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [ID_BITS-1:0]     out_id;
        logic [KEY_BITS-1:0]    out_key;
        logic [KEY_BITS-1:0]    front_key;
        logic [COUNT_BITS-1:0]  count;
    } rsp_beat_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [ID_BITS-1:0]  job_id;
    } entry_t;

endpackage

/* rtl/core/min_priority_queue_scan.sv */
`timescale 1ns / 1ps

// Channel  Valid      Stall      Beat
// -------  ---------  ---------  ---------------------------------
// request  req_valid  req_stall  req_beat (req_type, key, job_id)
// result   rsp_valid  rsp_stall  rsp_beat (status, id, keys, count)
//
// Insert and failed requests go from accept to S_DONE with no memory scan.
// A remove that leaves n > 0 entries reads the last entry, moves it into
// the freed slot (S_MOVE), then scans the n entries left on one port.
// Reset (rst_n low) empties the queue; the entry memory is not cleared.
// A valid result register holds while rsp_stall is high; the next request
// is taken once the previous result has entered that register.

module min_priority_queue_scan #(
    parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  mpq_pkg::req_beat_t req_beat,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output mpq_pkg::rsp_beat_t rsp_beat
);

    import mpq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_wdata;
    entry_t           mem_rdata;
    logic             res_valid;
    logic             res_take;
    rsp_beat_t        res_beat;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_beat_t        rsp_beat_reg;

    mpq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mpq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_beat  (res_beat),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    assign res_take       = res_valid && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid_next = res_take || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_beat_reg <= res_beat;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

`ifndef SYNTHESIS
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_beat.status == STATUS_FULL))
        |-> (rsp_beat.count == COUNT_BITS'(DEPTH)))
        else $error("full status with count below depth");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_beat.status == STATUS_EMPTY))
        |-> ((rsp_beat.count == '0) && (rsp_beat.front_key == '1)))
        else $error("empty status with entries held");

    a_removed_is_min: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_beat.status == STATUS_OK))
        |-> (rsp_beat.out_key <= rsp_beat.front_key))
        else $error("removed key above new front key");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while busy");
`endif

endmodule

/* rtl/core/mpq_mem.sv */
`timescale 1ns / 1ps

module mpq_mem #(
    parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  mpq_pkg::entry_t          wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output mpq_pkg::entry_t          rdata
);

    import mpq_pkg::*;

    entry_t entry_mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
        rdata_reg <= entry_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/mpq_ctrl.sv */
`timescale 1ns / 1ps

module mpq_ctrl #(
    parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  mpq_pkg::req_beat_t       req_beat,
    output logic                     res_valid,
    input  logic                     res_take,
    output mpq_pkg::rsp_beat_t       res_beat,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output mpq_pkg::entry_t          mem_wdata,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    input  mpq_pkg::entry_t          mem_rdata
);

    import mpq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOVE = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    function automatic logic entry_less(input entry_t a, input entry_t b);
        return (a.key < b.key) || ((a.key == b.key) && (a.job_id < b.job_id));
    endfunction

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       occ_reg, occ_next;
    logic [CNT_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_slot_reg, pend_slot_next;
    entry_t                 min_reg, min_next;
    logic [IDX_W-1:0]       min_slot_reg, min_slot_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    entry_t                 rem_reg, rem_next;
    logic                   accept;
    entry_t                 new_entry;
    logic [IDX_W-1:0]       last_slot;

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);
    assign new_entry = '{key: req_beat.key, job_id: req_beat.job_id};
    assign last_slot = IDX_W'(occ_reg - CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        scan_cnt_next  = scan_cnt_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        min_next       = min_reg;
        min_slot_next  = min_slot_reg;
        status_next    = status_reg;
        rem_next       = rem_reg;
        mem_we         = 1'b0;
        mem_waddr      = min_slot_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = scan_cnt_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = STATUS_OK;
                    rem_next    = '0;
                    state_next  = S_DONE;
                    if (req_beat.req_type == REQ_INSERT)
                    begin
                        if (occ_reg == FULL_CNT)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = occ_reg[IDX_W-1:0];
                            mem_wdata = new_entry;
                            occ_next  = occ_reg + CNT_W'(1);
                            if ((occ_reg == '0) || entry_less(new_entry, min_reg))
                            begin
                                min_next      = new_entry;
                                min_slot_next = occ_reg[IDX_W-1:0];
                            end
                        end
                    end
                    else
                    begin
                        if (occ_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            rem_next  = min_reg;
                            occ_next  = occ_reg - CNT_W'(1);
                            mem_raddr = last_slot;
                            if (occ_reg != CNT_W'(1))
                            begin
                                state_next = S_MOVE;
                            end
                        end
                    end
                end
            end
            S_MOVE:
            begin
                mem_we        = 1'b1;
                mem_waddr     = min_slot_reg;
                mem_wdata     = mem_rdata;
                scan_cnt_next = '0;
                pend_next     = 1'b0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_cnt_reg < occ_reg)
                begin
                    mem_raddr      = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next  = scan_cnt_reg + CNT_W'(1);
                    pend_next      = 1'b1;
                    pend_slot_next = scan_cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if ((pend_slot_reg == '0) || entry_less(mem_rdata, min_reg))
                    begin
                        min_next      = mem_rdata;
                        min_slot_next = pend_slot_reg;
                    end
                    if (pend_slot_reg == last_slot)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            scan_cnt_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            scan_cnt_reg <= scan_cnt_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        min_reg       <= min_next;
        min_slot_reg  <= min_slot_next;
        status_reg    <= status_next;
        rem_reg       <= rem_next;
    end

    assign res_valid          = (state_reg == S_DONE);
    assign res_beat.status    = status_reg;
    assign res_beat.out_id    = rem_reg.job_id;
    assign res_beat.out_key   = rem_reg.key;
    assign res_beat.front_key = (occ_reg == '0) ? '1 : min_reg.key;
    assign res_beat.count     = COUNT_BITS'(occ_reg);

endmodule
